// ===== sv/oaid_pkg.sv =====
package oaid_pkg;

    // Field widths fixed by the request and result formats.
    localparam int SLOT_W  = 6;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // Number of match flags examined per cycle while a search scans.
    localparam int SCAN_CHUNK = 16;

    // Request mode codes.
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_SEARCH = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    typedef struct packed {
        logic [2:0]               mode;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic [SLOT_W-1:0]        found_slot;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     error;
    } rsp_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ===== sv/oaid_cell.sv =====
module oaid_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  oaid_pkg::cell_cmd_t                 cmd,
    input  logic signed [oaid_pkg::DATA_W-1:0]  left_entry,
    input  logic signed [oaid_pkg::DATA_W-1:0]  right_entry,
    output logic signed [oaid_pkg::DATA_W-1:0]  entry,
    output logic                                match
);

    logic signed [oaid_pkg::DATA_W-1:0] entry_reg;
    logic signed [oaid_pkg::DATA_W-1:0] entry_next;

    // Pick this position's next entry from the neighbors or the new value.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            oaid_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            oaid_pkg::CELL_INSERT:
            begin
                if (IDX > int'(cmd.slot))
                begin
                    entry_next = left_entry;
                end
                else if (IDX == int'(cmd.slot))
                begin
                    entry_next = cmd.value;
                end
            end
            oaid_pkg::CELL_DELETE:
            begin
                if (IDX >= int'(cmd.slot))
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The entry holds payload only, so it has no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == cmd.value);

endmodule

// ===== sv/ordered_array_insert_delete_search_top.sv =====
// Ordered array of signed 32-bit entries with clear, insert, delete, search and read.
// A request transfers when start is high and busy is low, and its result appears
// on rsp with done high for exactly one cycle, the cycle after the request, or
// after the scan for a search; the receiver cannot stall, so it must take every
// result in that cycle. Clear, insert, delete, read and unknown modes keep busy
// low, so one such request can transfer every cycle: every entry sits in its
// own cell of a chain, and all cells shift together. A search compares all
// cells at once, then scans the match flags 16 at a time and holds busy after
// the transfer while it scans: it stops at the first chunk that holds a match,
// or, when nothing matches, at the chunk that reaches the count (at least one
// chunk is always scanned).
// Entries hold no reset value and need no clearing pass; only entries below the
// count are ever read.
module ordered_array_insert_delete_search_top #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  oaid_pkg::req_t   req,
    output logic             done,
    output oaid_pkg::rsp_t   rsp
);

    localparam int SW     = oaid_pkg::SLOT_W;
    localparam int OW     = oaid_pkg::COUNT_W;
    localparam int DW     = oaid_pkg::DATA_W;
    localparam int CHUNK  = oaid_pkg::SCAN_CHUNK;
    localparam int IW     = $clog2(CHUNK);
    localparam int CNTW   = $clog2(DEPTH + 1);
    localparam int CMPW   = (CNTW > SW) ? CNTW : SW;
    localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int PADW   = NCHUNK * CHUNK;
    localparam int BW     = $clog2(PADW + 1);
    localparam int EW     = ((BW > CNTW) ? BW : CNTW) + 1;
    localparam int RDN    = (DEPTH < (1 << SW)) ? DEPTH : (1 << SW);

    oaid_pkg::state_t    state_reg;
    oaid_pkg::state_t    state_next;
    logic [CNTW-1:0]     count_reg;
    logic [CNTW-1:0]     count_next;
    logic [PADW-1:0]     hits_reg;
    logic [PADW-1:0]     hits_next;
    logic [BW-1:0]       base_reg;
    logic [BW-1:0]       base_next;
    logic                done_reg;
    logic                done_next;
    oaid_pkg::rsp_t      rsp_reg;
    oaid_pkg::rsp_t      rsp_next;

    logic                accept;
    logic                is_search;
    logic                req_error;
    oaid_pkg::cell_op_t  req_op;
    oaid_pkg::cell_cmd_t cell_cmd;
    logic signed [DW-1:0] rd_value;
    logic [CMPW-1:0]     slot_ext;
    logic [CMPW-1:0]     cnt_ext;
    logic [DEPTH-1:0]    hit_cap;
    logic [CHUNK-1:0]    low_chunk;
    logic                chunk_hit;
    logic [IW-1:0]       low_idx;
    logic [BW-1:0]       scan_pos;
    logic                scan_last;
    logic                scan_end;
    logic                scanning;

    logic signed [DW-1:0] entry [DEPTH];
    logic signed [DW-1:0] left  [DEPTH];
    logic signed [DW-1:0] right [DEPTH];
    logic                 match [DEPTH];

    assign accept   = start && !busy;
    assign slot_ext = CMPW'(req.slot);
    assign cnt_ext  = CMPW'(count_reg);

    // Decode the request against the current count.
    always_comb
    begin
        req_error  = 1'b0;
        count_next = count_reg;
        req_op     = oaid_pkg::CELL_HOLD;
        is_search  = 1'b0;
        rd_value   = '0;
        unique case (req.mode)
            oaid_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            oaid_pkg::MODE_INSERT:
            begin
                if ((cnt_ext >= CMPW'(DEPTH)) || (slot_ext > cnt_ext))
                begin
                    req_error = 1'b1;
                end
                else
                begin
                    req_op     = oaid_pkg::CELL_INSERT;
                    count_next = CNTW'(count_reg + 1'b1);
                end
            end
            oaid_pkg::MODE_DELETE:
            begin
                if (slot_ext >= cnt_ext)
                begin
                    req_error = 1'b1;
                end
                else
                begin
                    req_op     = oaid_pkg::CELL_DELETE;
                    count_next = CNTW'(count_reg - 1'b1);
                end
            end
            oaid_pkg::MODE_SEARCH:
            begin
                is_search = 1'b1;
            end
            oaid_pkg::MODE_READ:
            begin
                if (slot_ext >= cnt_ext)
                begin
                    req_error = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < RDN; i++)
                    begin
                        if (req.slot == SW'(i))
                        begin
                            rd_value = entry[i];
                        end
                    end
                end
            end
            default:
            begin
                req_error = 1'b1;
            end
        endcase
    end

    // Command broadcast to the chain; cells move only on an accepted transfer.
    always_comb
    begin
        cell_cmd.op    = accept ? req_op : oaid_pkg::CELL_HOLD;
        cell_cmd.slot  = req.slot;
        cell_cmd.value = req.item_value;
    end

    // The chain of cells, each wired to its two neighbors.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left[g] = '0;
        end
        else
        begin : g_left
            assign left[g] = entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right[g] = '0;
        end
        else
        begin : g_right
            assign right[g] = entry[g+1];
        end

        oaid_cell #(
            .IDX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .left_entry  (left[g]),
            .right_entry (right[g]),
            .entry       (entry[g]),
            .match       (match[g])
        );
    end

    // Match flags of valid positions, captured when a search transfers.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_cap[i] = match[i] && (CNTW'(i) < count_reg);
        end
    end

    // Lowest match in the chunk at the bottom of the flag shift register.
    always_comb
    begin
        low_chunk = hits_reg[CHUNK-1:0];
        chunk_hit = |low_chunk;
        low_idx   = '0;
        for (int j = CHUNK - 1; j >= 0; j--)
        begin
            if (low_chunk[j])
            begin
                low_idx = IW'(j);
            end
        end
        scan_pos  = base_reg + BW'(low_idx);
        scan_last = (EW'(base_reg) + EW'(CHUNK)) >= EW'(count_reg);
        scan_end  = chunk_hit || scan_last;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oaid_pkg::ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = oaid_pkg::ST_SCAN;
                end
            end
            oaid_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = oaid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oaid_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy     = 1'b0;
        scanning = 1'b0;
        unique case (state_reg)
            oaid_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                scanning = 1'b0;
            end
            oaid_pkg::ST_SCAN:
            begin
                busy     = 1'b1;
                scanning = 1'b1;
            end
            default:
            begin
                busy     = 1'b0;
                scanning = 1'b0;
            end
        endcase
    end

    // Flag shift register and scan base.
    always_comb
    begin
        hits_next = hits_reg;
        base_next = base_reg;
        if (accept && is_search)
        begin
            hits_next = PADW'(hit_cap);
            base_next = '0;
        end
        else if (scanning)
        begin
            hits_next = hits_reg >> CHUNK;
            base_next = base_reg + BW'(CHUNK);
        end
    end

    // Result register and strobe.
    always_comb
    begin
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        if (accept && !is_search)
        begin
            done_next            = 1'b1;
            rsp_next.found       = 1'b0;
            rsp_next.found_slot  = '0;
            rsp_next.read_value  = rd_value;
            rsp_next.entry_count = OW'(count_next);
            rsp_next.error       = req_error;
        end
        else if (scanning && scan_end)
        begin
            done_next            = 1'b1;
            rsp_next.found       = chunk_hit;
            rsp_next.found_slot  = chunk_hit ? SW'(scan_pos) : '0;
            rsp_next.read_value  = '0;
            rsp_next.entry_count = OW'(count_reg);
            rsp_next.error       = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oaid_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hits_reg <= hits_next;
        base_reg <= base_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/oaid_check.sv =====
module oaid_check (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  oaid_pkg::req_t req,
    input  logic           done,
    input  oaid_pkg::rsp_t rsp
);

    // A request other than search is answered in the next cycle.
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.mode != oaid_pkg::MODE_SEARCH)) |=> done)
        else $error("non-search transfer not answered in the next cycle");

    // A search holds busy and shows no result in the next cycle.
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.mode == oaid_pkg::MODE_SEARCH)) |=> (busy && !done))
        else $error("search transfer did not start a scan");

    // A result is never shown while a scan is still running.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Clear always succeeds and leaves the array empty.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.mode == oaid_pkg::MODE_CLEAR))
        |=> (done && (rsp.entry_count == '0) && !rsp.error))
        else $error("clear did not empty the array");

endmodule

bind ordered_array_insert_delete_search_top oaid_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
